[rtl/ppsf_pkg.sv]
// ----------------------------------------------------------------------------
// ppsf_pkg
// Shared types and constants of the peer packet sequence filter: item
// layouts, register indexes, reject codes and reset values.
// ----------------------------------------------------------------------------
package ppsf_pkg;

    localparam int PLAYERS_DEF = 5;   // default peer count
    localparam int MASK_W      = 5;   // dead mask covers peers 1..5
    localparam int TIME_W      = 48;
    localparam int SEQ_W       = 31;
    localparam int LSEQ_W      = 32;  // stored sequence, signed
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Register reset values
    localparam logic [7:0]        MY_TEAM_RST      = 8'd0;
    localparam logic [SEQ_W-1:0]  RESTART_THR_RST  = 31'd100;
    localparam logic [15:0]       MIN_DELAY_RST    = 16'd0;
    localparam logic [31:0]       DEAD_THR_RST     = 32'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MY_TEAM     = 2'd0,
        CFG_RESTART_THR = 2'd1,
        CFG_MIN_DELAY   = 2'd2,
        CFG_DEAD_THR    = 2'd3
    } t_cfg_idx;

    // Command codes
    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_CHECK  = 1'b1
    } t_cmd;

    // Reject reasons
    typedef enum logic [2:0] {
        RSN_OK       = 3'd0,
        RSN_HEADER   = 3'd1,
        RSN_TEAM     = 3'd2,
        RSN_RANGE    = 3'd3,
        RSN_UNWANTED = 3'd4,
        RSN_STALE    = 3'd5
    } t_reason;

    typedef struct packed {
        logic              cmd;
        logic              header_ok;
        logic [7:0]        team_id;
        logic [7:0]        sender_player;
        logic [SEQ_W-1:0]  seq_number;
        logic [TIME_W-1:0] sent_time;
        logic [TIME_W-1:0] event_time;
        logic [2:0]        player_select;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        t_reason            reject_reason;
        logic signed [31:0] dropped_count;
        logic [TIME_W-1:0]  offset_added;
        logic [MASK_W-1:0]  dead_mask;
    } t_out_item;

endpackage

[rtl/peer_packet_seq_filter_core.sv]
// ----------------------------------------------------------------------------
// peer_packet_seq_filter_core
// Replay filter for peer packets with per-peer sequence tracking and a
// liveness check over the peers' last-seen times.
// ----------------------------------------------------------------------------
// Each item is either a received packet or a liveness check, and each gives
// exactly one result. An item is taken on a clock edge with i_start high and
// o_busy low; o_busy stays low, so a new item may be taken every cycle. The
// item lands in an input register, is evaluated in one pass of logic against
// the per-peer table, and its result is registered on the next edge: it shows
// on o_result with o_done high for a single cycle and is taken
// by the receiver at the edge that closes that cycle. The receiver
// cannot stall: o_done marks the only cycle in which a result is present.
// Table updates of an accepted packet land on the same edge as its result is
// registered, so the following item already sees them. Configuration writes
// take effect at the edge that samples i_cfg_we and belong in idle time only.
// ----------------------------------------------------------------------------
module peer_packet_seq_filter_core #(
    parameter int PLAYERS = ppsf_pkg::PLAYERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel
    input  logic                                i_start,
    output logic                                o_busy,
    input  ppsf_pkg::t_in_item                  i_item,
    // Result channel
    output logic                                o_done,
    output ppsf_pkg::t_out_item                 o_result,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [ppsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppsf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
    localparam int TW     = ppsf_pkg::TIME_W;
    localparam int LW     = ppsf_pkg::LSEQ_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]                 r_my_team;
    logic [ppsf_pkg::SEQ_W-1:0] r_restart_thr;
    logic [15:0]                r_min_delay;
    logic [31:0]                r_dead_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_team     <= ppsf_pkg::MY_TEAM_RST;
            r_restart_thr <= ppsf_pkg::RESTART_THR_RST;
            r_min_delay   <= ppsf_pkg::MIN_DELAY_RST;
            r_dead_thr    <= ppsf_pkg::DEAD_THR_RST;
        end else if (i_cfg_we) begin
            case (ppsf_pkg::t_cfg_idx'(i_cfg_idx))
                ppsf_pkg::CFG_MY_TEAM:     r_my_team     <= i_cfg_data[7:0];
                ppsf_pkg::CFG_RESTART_THR: r_restart_thr <= i_cfg_data[ppsf_pkg::SEQ_W-1:0];
                ppsf_pkg::CFG_MIN_DELAY:   r_min_delay   <= i_cfg_data[15:0];
                ppsf_pkg::CFG_DEAD_THR:    r_dead_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture every started item
    // ------------------------------------------------------------------
    logic               r_in_valid;
    ppsf_pkg::t_in_item r_in;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in <= i_item;
        end
    end

    // ------------------------------------------------------------------
    // Evaluation
    // ------------------------------------------------------------------
    logic [7:0]            w_sender_m1;
    logic [IDX_W-1:0]      w_idx;
    logic signed [LW-1:0]  w_prev;
    logic signed [LW-1:0]  w_seq;
    logic [LW:0]           w_dist;
    logic                  w_stale;
    logic [TW:0]           w_ahead;
    logic [TW:0]           w_excess;
    logic                  w_late;
    logic [TW-1:0]         w_offset;
    logic [TW-1:0]         w_seen;
    logic [ppsf_pkg::MASK_W-1:0] w_dead_mask;
    logic                  w_wr_en;
    ppsf_pkg::t_reason     w_reason;
    ppsf_pkg::t_out_item   n_out;

    assign w_sender_m1 = r_in.sender_player - 8'd1;
    assign w_idx       = w_sender_m1[IDX_W-1:0];
    assign w_seq       = {1'b0, r_in.seq_number};

    // Stale: at or below the stored value and closer than the restart
    // distance. The distance is only looked at when it is non-negative.
    assign w_dist  = {w_prev[LW-1], w_prev} - {1'b0, w_seq};
    assign w_stale = (w_seq <= w_prev) && (w_dist[LW-1:0] < {1'b0, r_restart_thr});

    // Clock offset: how far sent_time plus the minimum delay runs ahead of
    // the receive time, saturated to the time width.
    assign w_ahead  = {1'b0, r_in.sent_time} + {{(TW+1-16){1'b0}}, r_min_delay};
    assign w_late   = w_ahead > {1'b0, r_in.event_time};
    assign w_excess = w_ahead - {1'b0, r_in.event_time};
    assign w_offset = !w_late ? '0 : (w_excess[TW] ? ppsf_pkg::TIME_MAX : w_excess[TW-1:0]);
    // Receive time plus offset equals the ahead time when late.
    assign w_seen   = !w_late ? r_in.event_time
                    : (w_ahead[TW] ? ppsf_pkg::TIME_MAX : w_ahead[TW-1:0]);

    // Checks in priority order; first failure names the reason
    always_comb begin
        if (!r_in.header_ok) begin
            w_reason = ppsf_pkg::RSN_HEADER;
        end else if (r_in.team_id != r_my_team) begin
            w_reason = ppsf_pkg::RSN_TEAM;
        end else if ((r_in.sender_player == 8'd0) || (r_in.sender_player > 8'(PLAYERS))) begin
            w_reason = ppsf_pkg::RSN_RANGE;
        end else if ((r_in.player_select != 3'd0)
                     && ({5'd0, r_in.player_select} != r_in.sender_player)) begin
            w_reason = ppsf_pkg::RSN_UNWANTED;
        end else if (w_stale) begin
            w_reason = ppsf_pkg::RSN_STALE;
        end else begin
            w_reason = ppsf_pkg::RSN_OK;
        end
    end

    assign w_wr_en = r_in_valid && (r_in.cmd == ppsf_pkg::CMD_PACKET)
                   && (w_reason == ppsf_pkg::RSN_OK);

    always_comb begin
        n_out = '0;
        if (r_in.cmd == ppsf_pkg::CMD_CHECK) begin
            n_out.dead_mask = w_dead_mask;
        end else begin
            n_out.reject_reason = w_reason;
            if (w_reason == ppsf_pkg::RSN_OK) begin
                n_out.accepted      = 1'b1;
                n_out.dropped_count = w_seq - w_prev - 32'sd1;
                n_out.offset_added  = w_offset;
            end
        end
    end

    ppsf_peer_table #(
        .PLAYERS (PLAYERS),
        .IDX_W   (IDX_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_wr_en),
        .i_wr_idx    (w_idx),
        .i_wr_seq    (w_seq),
        .i_wr_seen   (w_seen),
        .i_rd_idx    (w_idx),
        .o_rd_seq    (w_prev),
        .i_now       (r_in.event_time),
        .i_skip      (r_in.player_select),
        .i_dead_thr  (r_dead_thr),
        .o_dead_mask (w_dead_mask)
    );

    // ------------------------------------------------------------------
    // Result register: each result shows with o_done high for exactly one cycle
    // ------------------------------------------------------------------
    logic                r_out_valid;
    ppsf_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/ppsf_peer_table.sv]
// ----------------------------------------------------------------------------
// ppsf_peer_table
// Per-peer state: last accepted sequence number and last-seen time, with
// one read port for the sequence and parallel liveness compares.
// ----------------------------------------------------------------------------
module ppsf_peer_table #(
    parameter int PLAYERS = ppsf_pkg::PLAYERS_DEF,
    parameter int IDX_W   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [IDX_W-1:0]                  i_wr_idx,
    input  logic signed [ppsf_pkg::LSEQ_W-1:0] i_wr_seq,
    input  logic [ppsf_pkg::TIME_W-1:0]       i_wr_seen,
    input  logic [IDX_W-1:0]                  i_rd_idx,
    output logic signed [ppsf_pkg::LSEQ_W-1:0] o_rd_seq,
    input  logic [ppsf_pkg::TIME_W-1:0]       i_now,
    input  logic [2:0]                        i_skip,
    input  logic [31:0]                       i_dead_thr,
    output logic [ppsf_pkg::MASK_W-1:0]       o_dead_mask
);

    logic signed [ppsf_pkg::LSEQ_W-1:0] r_last_seq  [PLAYERS];
    logic [ppsf_pkg::TIME_W-1:0]        r_last_seen [PLAYERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLAYERS; i++) begin
                r_last_seq[i]  <= '1;
                r_last_seen[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_last_seq[i_wr_idx]  <= i_wr_seq;
            r_last_seen[i_wr_idx] <= i_wr_seen;
        end
    end

    assign o_rd_seq = r_last_seq[i_rd_idx];

    // A peer is dead when it is not skipped and now - last_seen, taken as
    // signed, exceeds the threshold; a peer seen in the future never is.
    for (genvar g = 0; g < ppsf_pkg::MASK_W; g++) begin : g_live
        if (g < PLAYERS) begin : g_peer
            logic [ppsf_pkg::TIME_W:0] w_diff;
            assign w_diff = {1'b0, i_now} - {1'b0, r_last_seen[g]};
            assign o_dead_mask[g] = (i_skip != 3'(g + 1)) && !w_diff[ppsf_pkg::TIME_W]
                && (w_diff[ppsf_pkg::TIME_W-1:0] > {16'd0, i_dead_thr});
        end else begin : g_none
            assign o_dead_mask[g] = 1'b0;
        end
    end

endmodule

[rtl/ppsf_checker.sv]
// ----------------------------------------------------------------------------
// ppsf_checker
// Port-level checks of the peer packet sequence filter, bound to the core.
// ----------------------------------------------------------------------------
module ppsf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input ppsf_pkg::t_in_item  i_item,
    input logic                o_done,
    input ppsf_pkg::t_out_item o_result
);

    // Every taken item gives a result once it has passed the input and result registers
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_done)
        else $error("taken item gave no result");

    // No result without an item taken before it
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 2))
        else $error("result without a taken item");

    // An accepted packet carries no reason and no dead mask
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.accepted) |->
            (o_result.reject_reason == ppsf_pkg::RSN_OK) && (o_result.dead_mask == '0))
        else $error("accepted packet with reason or mask");

    // A liveness check reports nothing but the mask
    a_check_mask_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.cmd, 2)) |->
            !o_result.accepted && (o_result.reject_reason == ppsf_pkg::RSN_OK)
            && (o_result.dropped_count == '0) && (o_result.offset_added == '0))
        else $error("liveness check with packet fields set");

endmodule

bind peer_packet_seq_filter_core ppsf_checker u_ppsf_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: peer packet sequence filter
// Drives received packets and liveness checks into the filter core, mirrors
// its per-peer sequence and last-seen tables in a scoreboard, and compares
// every result field by field. A short directed pass covers the reject
// causes, restarts, saturation and the skip of the own player. Random traffic
// then runs under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import ppsf_pkg::*;

    localparam int  STUCK_LIMIT     = 1000;  // cycles with no item and no result
    localparam int  PHASES          = 6;
    localparam int  ITEMS_PER_PHASE = 117;
    localparam int  SETTLE_CYCLES   = 4;     // idle time before each phase's register writes
    localparam longint T_MAX        = 64'h0000_FFFF_FFFF_FFFF;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and per-peer tables, a queue of
    // verdicts still owed by the block, and the mismatch counter.
    // ------------------------------------------------------------------------
    class peer_filter_scoreboard;
        localparam int N_PEERS = PLAYERS_DEF;

        logic [7:0]         my_team;
        logic [SEQ_W-1:0]   restart_thr;
        logic [15:0]        min_delay;
        logic [31:0]        dead_thr;
        logic signed [31:0] last_seq [N_PEERS];
        logic [TIME_W-1:0]  last_seen [N_PEERS];

        t_out_item pending_verdicts [$];
        int errors;
        int n_items;
        int n_results;
        int n_checks;
        int n_dead_flags;
        int n_offsets;
        int by_reason [6];

        function new();
            my_team     = MY_TEAM_RST;
            restart_thr = RESTART_THR_RST;
            min_delay   = MIN_DELAY_RST;
            dead_thr    = DEAD_THR_RST;
            for (int i = 0; i < N_PEERS; i++) begin
                last_seq[i]  = -32'sd1;
                last_seen[i] = '0;
            end
            errors = 0;
            n_items = 0;
            n_results = 0;
            n_checks = 0;
            n_dead_flags = 0;
            n_offsets = 0;
            for (int r = 0; r < 6; r++) by_reason[r] = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_MY_TEAM:     my_team     = data[7:0];
                CFG_RESTART_THR: restart_thr = data[SEQ_W-1:0];
                CFG_MIN_DELAY:   min_delay   = data[15:0];
                CFG_DEAD_THR:    dead_thr    = data;
                default: ;
            endcase
        endfunction

        // Work out the verdict for one item and advance the tables.
        function t_out_item screen_item(t_in_item it);
            t_out_item v;
            longint now, prev, seq, ahead, off, seen, diff;
            int idx;
            v = '0;
            v.reject_reason = RSN_OK;
            now = longint'({16'd0, it.event_time});
            if (it.cmd == CMD_CHECK) begin
                for (int i = 0; i < N_PEERS && i < MASK_W; i++) begin
                    // signed age: a peer seen in the future is never dead
                    diff = now - longint'({16'd0, last_seen[i]});
                    if (it.player_select != 3'(i + 1) &&
                        diff > longint'({32'd0, dead_thr}))
                        v.dead_mask[i] = 1'b1;
                end
            end else if (!it.header_ok) begin
                v.reject_reason = RSN_HEADER;
            end else if (it.team_id != my_team) begin
                v.reject_reason = RSN_TEAM;
            end else if (it.sender_player < 8'd1 || int'(it.sender_player) > N_PEERS) begin
                v.reject_reason = RSN_RANGE;
            end else if (it.player_select != 3'd0 &&
                         {5'd0, it.player_select} != it.sender_player) begin
                v.reject_reason = RSN_UNWANTED;
            end else begin
                idx  = int'(it.sender_player) - 1;
                prev = longint'(last_seq[idx]);
                seq  = longint'({33'd0, it.seq_number});
                if (seq <= prev && (prev - seq) < longint'({33'd0, restart_thr})) begin
                    v.reject_reason = RSN_STALE;
                end else begin
                    v.accepted      = 1'b1;
                    v.dropped_count = 32'(seq - prev - 1);
                    last_seq[idx]   = 32'(seq);
                    ahead = longint'({16'd0, it.sent_time}) + longint'({48'd0, min_delay});
                    off   = 0;
                    if (ahead > now) off = ahead - now;
                    if (off > T_MAX) off = T_MAX;
                    seen = now + off;
                    if (seen > T_MAX) seen = T_MAX;
                    last_seen[idx]  = seen[TIME_W-1:0];
                    v.offset_added  = off[TIME_W-1:0];
                end
            end
            return v;
        endfunction

        function void take_item(t_in_item it);
            t_out_item v;
            v = screen_item(it);
            pending_verdicts.push_back(v);
            n_items++;
            if (it.cmd == CMD_CHECK) begin
                n_checks++;
                n_dead_flags += $countones(v.dead_mask);
            end else begin
                by_reason[int'(v.reject_reason)]++;
                if (v.offset_added != '0) n_offsets++;
            end
        endfunction

        function void report(string what);
            errors++;
            $display("MISMATCH %0d: %s", errors, what);
        endfunction

        function void match_verdict(t_out_item got);
            t_out_item want;
            n_results++;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result %0d arrived with none owed: %h", n_results, got));
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.accepted !== want.accepted)
                report($sformatf("result %0d accepted %b, want %b",
                                 n_results, got.accepted, want.accepted));
            if (got.reject_reason !== want.reject_reason)
                report($sformatf("result %0d reject_reason %0d, want %0d",
                                 n_results, got.reject_reason, want.reject_reason));
            if (got.dropped_count !== want.dropped_count)
                report($sformatf("result %0d dropped_count %0d, want %0d",
                                 n_results, got.dropped_count, want.dropped_count));
            if (got.offset_added !== want.offset_added)
                report($sformatf("result %0d offset_added %h, want %h",
                                 n_results, got.offset_added, want.offset_added));
            if (got.dead_mask !== want.dead_mask)
                report($sformatf("result %0d dead_mask %b, want %b",
                                 n_results, got.dead_mask, want.dead_mask));
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports; the inputs are all known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_start    = 1'b0;
    logic                  o_busy;
    t_in_item              i_item     = '0;
    logic                  o_done;
    t_out_item             o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    peer_filter_scoreboard sb;
    int     stuck_cycles = 0;
    longint clock_base   = 1000;   // running receive time for random traffic

    always #2 i_clk = ~i_clk;

    peer_packet_seq_filter_core #(
        .PLAYERS (PLAYERS_DEF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check the result of the cycle that
    // just ended, then note any item taken on this edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.match_verdict(o_result);
            if (i_start && !o_busy) sb.take_item(i_item);
            if (o_done || (i_start && !o_busy))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("Watchdog: no item taken and no result for %0d cycles", STUCK_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Fully random item: fills don't-care fields and idle cycles
    function automatic t_in_item junk_item();
        logic [159:0] w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return w[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item pkt(logic hdr, logic [7:0] team, logic [7:0] who,
                                     logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] sent,
                                     logic [TIME_W-1:0] now, logic [2:0] sel);
        t_in_item it;
        it = junk_item();
        it.cmd           = CMD_PACKET;
        it.header_ok     = hdr;
        it.team_id       = team;
        it.sender_player = who;
        it.seq_number    = seq;
        it.sent_time     = sent;
        it.event_time    = now;
        it.player_select = sel;
        return it;
    endfunction

    function automatic t_in_item chk(logic [TIME_W-1:0] now, logic [2:0] sel);
        t_in_item it;
        it = junk_item();
        it.cmd           = CMD_CHECK;
        it.event_time    = now;
        it.player_select = sel;
        return it;
    endfunction

    // Random traffic: mostly well-formed packets from known peers with
    // sequence numbers near the stored ones, plus liveness checks and noise.
    function automatic t_in_item make_traffic_item();
        t_in_item it;
        longint prev, s, st, now;
        int who;
        it = junk_item();
        clock_base += $urandom_range(40);
        case ($urandom_range(39))
            0:       now = longint'({16'd0, rand48()});
            1:       now = T_MAX;
            default: now = clock_base;
        endcase
        it.event_time = now[TIME_W-1:0];
        if ($urandom_range(99) < 25) begin
            it.cmd = CMD_CHECK;
            return it;
        end
        it.cmd       = CMD_PACKET;
        it.header_ok = ($urandom_range(99) < 95);
        if ($urandom_range(99) < 92) it.team_id = sb.my_team;
        if ($urandom_range(99) < 85) it.sender_player = 8'($urandom_range(PLAYERS_DEF, 1));
        who = int'(it.sender_player);
        case ($urandom_range(19))
            0, 1, 2:   it.player_select = 3'($urandom_range(7));
            3, 4, 5, 6, 7:
                       it.player_select = (who >= 1 && who <= PLAYERS_DEF) ? 3'(who) : 3'd0;
            default:   it.player_select = 3'd0;
        endcase
        prev = (who >= 1 && who <= PLAYERS_DEF) ? longint'(sb.last_seq[who-1]) : -1;
        case ($urandom_range(9))
            0, 1, 2, 3: s = prev + 1;
            4, 5:       s = prev + 1 + $urandom_range(50, 1);
            6:          s = prev - $urandom_range(3);
            7:          s = prev - longint'({33'd0, sb.restart_thr});      // just restarted
            8:          s = prev - longint'({33'd0, sb.restart_thr}) + 1;  // just stale
            default:    s = -1;
        endcase
        if (s < 0 || s > 64'h7FFF_FFFF) s = longint'({33'd0, 31'($urandom)});
        it.seq_number = s[SEQ_W-1:0];
        case ($urandom_range(19))
            0:       st = longint'({16'd0, rand48()});
            1:       st = T_MAX;
            2, 3:    st = now + $urandom_range(300, 1);
            default: st = now - $urandom_range(200);
        endcase
        if (st < 0) st = 0;
        if (st > T_MAX) st = T_MAX;
        it.sent_time = st[TIME_W-1:0];
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: every task begins at a falling edge, so each input gets at
    // most one update per time step.
    // ------------------------------------------------------------------------
    task automatic send_item(bit fresh, t_in_item it);
        @(negedge i_clk);
        if (fresh) it = make_traffic_item();
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_one();
        @(negedge i_clk);
        i_start <= 1'b0;
        i_item  <= junk_item();
    endtask

    // Hold the sender off until every owed result has come back
    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        i_item  <= junk_item();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_register(idx, data);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int          idle_pct [PHASES];
        logic [7:0]  team;
        logic [30:0] thr;
        logic [15:0] dly;
        logic [31:0] dead;
        bit          quiet;

        idle_pct = '{0, 55, 0, 26, 55, 0};
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass under reset settings: team 0, restart distance 100,
        // no transit delay, dead after any silence.
        send_item(0, chk(48'd0, 3'd0));                        // nobody silent yet
        send_item(0, chk(48'd1, 3'd0));                        // everybody silent
        send_item(0, chk(48'd1, 3'd7));                        // own player out of range
        send_item(0, chk(48'd1, 3'd3));                        // skip own player
        send_item(0, pkt(1'b0, 8'd0, 8'd1, 31'd1, 48'd0, 48'd5, 3'd0));     // bad header
        send_item(0, pkt(1'b1, 8'hFF, 8'd1, 31'd1, 48'd0, 48'd5, 3'd0));    // wrong team
        send_item(0, pkt(1'b1, 8'd0, 8'd0, 31'd1, 48'd0, 48'd5, 3'd0));     // player zero
        send_item(0, pkt(1'b1, 8'd0, 8'd6, 31'd1, 48'd0, 48'd5, 3'd0));     // above range
        send_item(0, pkt(1'b1, 8'd0, 8'hFF, 31'd1, 48'd0, 48'd5, 3'd0));
        send_item(0, pkt(1'b1, 8'd0, 8'd2, 31'd1, 48'd0, 48'd5, 3'd3));     // unwanted
        send_item(0, pkt(1'b1, 8'd0, 8'd5, 31'd1, 48'd0, 48'd5, 3'd7));     // nobody wanted
        send_item(0, pkt(1'b1, 8'd0, 8'd1, 31'd0, 48'd0, 48'd10, 3'd1));    // first seq
        send_item(0, pkt(1'b1, 8'd0, 8'd1, 31'd0, 48'd0, 48'd11, 3'd0));    // replay
        send_item(0, pkt(1'b1, 8'd0, 8'd1, 31'd5, 48'd20, 48'd12, 3'd0));   // gap, offset
        send_item(0, pkt(1'b1, 8'd0, 8'd2, 31'h7FFF_FFFF, TIME_MAX, 48'd0, 3'd0));
        send_item(0, pkt(1'b1, 8'd0, 8'd2, 31'd0, 48'd0, 48'd50, 3'd2));    // restart at top
        send_item(0, pkt(1'b1, 8'd0, 8'd3, 31'd200, 48'd40, 48'd60, 3'd0));
        send_item(0, pkt(1'b1, 8'd0, 8'd3, 31'd101, 48'd40, 48'd61, 3'd0)); // one short
        send_item(0, pkt(1'b1, 8'd0, 8'd3, 31'd100, 48'd40, 48'd62, 3'd0)); // at threshold
        send_item(0, pkt(1'b1, 8'd0, 8'd4, 31'd10, 48'd0, TIME_MAX, 3'd0)); // seen at max
        send_item(0, chk(TIME_MAX, 3'd0));
        send_item(0, chk(48'd0, 3'd5));                        // peers in the future
        send_item(0, chk(48'd70, 3'd0));

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            case (phase)
                0: begin
                    team = 8'hFF; thr = '0; dly = 16'hFFFF; dead = 32'hFFFF_FFFF;
                end
                1: begin
                    team = 8'($urandom); thr = 31'h7FFF_FFFF; dly = '0; dead = '0;
                end
                2: begin
                    team = 8'($urandom); thr = 31'($urandom_range(64, 1));
                    dly = 16'($urandom_range(200)); dead = 32'($urandom_range(500, 50));
                end
                3: begin
                    team = 8'($urandom); thr = 31'd100;
                    dly = 16'($urandom_range(1000)); dead = 32'($urandom_range(2000, 100));
                end
                4: begin
                    team = 8'd0; thr = 31'($urandom); dly = 16'($urandom); dead = $urandom;
                end
                default: begin
                    team = 8'($urandom); thr = 31'($urandom_range(20, 1));
                    dly = 16'hFFFF; dead = 32'($urandom_range(300));
                end
            endcase
            // upper data bits beyond the team, restart and delay register widths carry noise
            write_reg(CFG_MY_TEAM,     {24'($urandom), team});
            write_reg(CFG_RESTART_THR, {1'($urandom), thr});
            write_reg(CFG_MIN_DELAY,   {16'($urandom), dly});
            write_reg(CFG_DEAD_THR,    dead);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                quiet = (k % 40) >= 30;  // burst with no gaps
                while (!quiet && $urandom_range(99) < idle_pct[phase]) idle_one();
                if (phase == 2 && k == ITEMS_PER_PHASE / 2) drain();
                send_item(1, '0);
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Covered %0d items over 7 register settings: %0d checks raising %0d dead flags",
                 sb.n_items, sb.n_checks, sb.n_dead_flags);
        $display("Packets accepted %0d (%0d with offset); rejected header %0d team %0d %s",
                 sb.by_reason[RSN_OK], sb.n_offsets, sb.by_reason[RSN_HEADER],
                 sb.by_reason[RSN_TEAM],
                 $sformatf("range %0d unwanted %0d stale %0d", sb.by_reason[RSN_RANGE],
                           sb.by_reason[RSN_UNWANTED], sb.by_reason[RSN_STALE]));
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
